// File: rtl/disk_seek_scheduler_top_assert.svh
// assertion macros for the disk seek scheduler checker
`ifndef DISK_SEEK_SCHEDULER_TOP_ASSERT_SVH
`define DISK_SEEK_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, quiet in reset
`define DSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, quiet in reset
`define DSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dss_pkg.sv
`default_nettype none

package dss_pkg;

  // sizes
  localparam int unsigned DSS_QUEUE_DEPTH = 32;
  localparam int unsigned TRACK_W         = 16;
  localparam int unsigned SUM_W           = 23;
  localparam int unsigned TOT_W           = 22;
  localparam int unsigned METHOD_W        = 2;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 16;

  // scheduling methods
  localparam logic [METHOD_W-1:0] METHOD_FCFS = 2'd0;
  localparam logic [METHOD_W-1:0] METHOD_SCAN = 2'd1;
  localparam logic [METHOD_W-1:0] METHOD_SSTF = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKS = 1'b1;

  // register reset values
  localparam logic [METHOD_W-1:0] METHOD_RESET = METHOD_FCFS;
  localparam logic [TRACK_W-1:0]  TRACKS_RESET = 16'hFFFF;

  // which track an arm move goes to
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_BEST,
    EMIT_FCFS,
    EMIT_EDGE
  } dss_emit_e;

  // which entries a search may pick
  typedef enum logic [1:0] {
    MODE_ANY,
    MODE_UP,
    MODE_DOWN
  } dss_mode_e;

  // controller to datapath
  typedef struct packed {
    logic      store;
    logic      start;
    logic      restart;
    logic      rd_en;
    logic      rd_cmp;
    dss_emit_e emit;
    logic      fin;
    logic      clear;
    dss_mode_e mode;
  } dss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [METHOD_W-1:0] method;
    logic                ptr_done;
    logic                found;
    logic                rem_zero;
    logic                rem_one;
    logic                out_free;
  } dss_sts_t;

endpackage

`default_nettype wire

// File: rtl/dss_req_if.sv
`default_nettype none

interface dss_req_if
  import dss_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] track;
  logic               last;

  modport source (output valid, output track, output last, input ready);
  modport sink   (input valid, input track, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/dss_res_if.sv
`default_nettype none

interface dss_res_if
  import dss_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] served_track;
  logic [TRACK_W-1:0] seek_distance;
  logic               at_edge;
  logic [TOT_W-1:0]   total_distance;
  logic               overflow;
  logic               final_res;

  modport source (
    output valid, output served_track, output seek_distance, output at_edge,
    output total_distance, output overflow, output final_res, input ready
  );
  modport sink (
    input valid, input served_track, input seek_distance, input at_edge,
    input total_distance, input overflow, input final_res, output ready
  );
endinterface

`default_nettype wire

// File: rtl/dss_datapath.sv
`default_nettype none

module dss_datapath
  import dss_pkg::*;
#(
  parameter int unsigned QueueDepth = DSS_QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [TRACK_W-1:0]    in_track_i,
  input  wire dss_cmd_t              cmd_i,
  output dss_sts_t                   sts_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [TRACK_W-1:0]         out_served_track_o,
  output logic [TRACK_W-1:0]         out_seek_distance_o,
  output logic                       out_at_edge_o,
  output logic [TOT_W-1:0]           out_total_distance_o,
  output logic                       out_overflow_o,
  output logic                       out_final_res_o
);

  localparam int unsigned AddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  // request store, read through a registered port
  logic [TRACK_W-1:0] mem_q [QueueDepth];

  logic [METHOD_W-1:0]   method_q;
  logic [TRACK_W-1:0]    tracks_q;
  logic [CntW-1:0]       count_q;
  logic [CntW-1:0]       ptr_q;
  logic [CntW-1:0]       rem_q;
  logic [QueueDepth-1:0] pend_q;
  logic                  dropped_q;
  logic [TRACK_W-1:0]    head_q;
  logic [SUM_W-1:0]      sum_q;
  logic [TRACK_W-1:0]    rd_data_q;
  logic                  rd_pend_q;
  logic [AddrW-1:0]      rd_idx_q;
  logic                  rd_cmp_q;
  logic                  found_q;
  logic [AddrW-1:0]      best_idx_q;
  logic [TRACK_W-1:0]    best_trk_q;
  logic [TRACK_W-1:0]    best_dist_q;
  logic                  out_valid_q;
  logic [TRACK_W-1:0]    out_trk_q;
  logic [TRACK_W-1:0]    out_dist_q;
  logic                  out_edge_q;
  logic [TOT_W-1:0]      out_tot_q;
  logic                  out_ovf_q;
  logic                  out_fin_q;

  logic [TRACK_W-1:0] sat_trk;
  logic               full;
  logic [TRACK_W-1:0] cand_dist;
  logic               qual;
  logic               hit;
  logic [TRACK_W-1:0] dest;
  logic [TRACK_W-1:0] emit_dist;
  logic [SUM_W-1:0]   sum_next;
  logic               out_free;

  // input saturation and store fill
  assign sat_trk = (in_track_i > tracks_q) ? tracks_q : in_track_i;
  assign full    = (count_q == CntW'(QueueDepth));

  // search compare on the entry read last cycle
  assign cand_dist = (rd_data_q > head_q) ? (rd_data_q - head_q) : (head_q - rd_data_q);

  always_comb begin
    case (cmd_i.mode)
      MODE_UP:   qual = (rd_data_q >= head_q);
      MODE_DOWN: qual = (rd_data_q <= head_q);
      default:   qual = 1'b1;
    endcase
  end

  assign hit = rd_cmp_q && rd_pend_q && qual && (!found_q || (cand_dist < best_dist_q));

  // arm move target, distance and running sum
  always_comb begin
    case (cmd_i.emit)
      EMIT_BEST: dest = best_trk_q;
      EMIT_FCFS: dest = rd_data_q;
      EMIT_EDGE: dest = tracks_q;
      default:   dest = head_q;
    endcase
  end

  assign emit_dist = (dest > head_q) ? (dest - head_q) : (head_q - dest);
  assign sum_next  = sum_q + SUM_W'(emit_dist);
  assign out_free  = !out_valid_q || out_ready_i;

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      mem_q[count_q[AddrW-1:0]] <= sat_trk;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[ptr_q[AddrW-1:0]];
      rd_pend_q <= pend_q[ptr_q[AddrW-1:0]];
      rd_idx_q  <= ptr_q[AddrW-1:0];
    end
  end

  // best candidate and output word payload
  always_ff @(posedge clk_i) begin
    if (hit) begin
      best_idx_q  <= rd_idx_q;
      best_trk_q  <= rd_data_q;
      best_dist_q <= cand_dist;
    end
    if (cmd_i.emit != EMIT_NONE) begin
      out_trk_q  <= dest;
      out_dist_q <= emit_dist;
      out_edge_q <= (cmd_i.emit == EMIT_EDGE);
      out_tot_q  <= sum_next[TOT_W-1:0];
      out_ovf_q  <= dropped_q;
      out_fin_q  <= cmd_i.fin;
    end
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q    <= METHOD_RESET;
      tracks_q    <= TRACKS_RESET;
      count_q     <= '0;
      ptr_q       <= '0;
      rem_q       <= '0;
      pend_q      <= '0;
      dropped_q   <= 1'b0;
      head_q      <= '0;
      sum_q       <= '0;
      rd_cmp_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_METHOD: method_q <= cfg_wdata_i[METHOD_W-1:0];
          CFG_TRACKS: tracks_q <= cfg_wdata_i[TRACK_W-1:0];
          default:    ;
        endcase
      end

      // request collection
      if (cmd_i.store) begin
        if (full) begin
          dropped_q <= 1'b1;
        end else begin
          pend_q[count_q[AddrW-1:0]] <= 1'b1;
          count_q <= count_q + 1'b1;
        end
      end

      // replay start
      if (cmd_i.start) begin
        head_q <= tracks_q >> 1;
        rem_q  <= count_q;
      end

      // scan pointer and best-so-far
      rd_cmp_q <= cmd_i.rd_en && cmd_i.rd_cmp;
      if (cmd_i.restart) begin
        ptr_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.rd_en) begin
          ptr_q <= ptr_q + 1'b1;
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end

      // arm move into the output register
      if (cmd_i.emit != EMIT_NONE) begin
        head_q      <= dest;
        sum_q       <= sum_next;
        out_valid_q <= 1'b1;
        if (cmd_i.emit == EMIT_BEST) begin
          pend_q[best_idx_q] <= 1'b0;
        end
        if (cmd_i.emit == EMIT_BEST || cmd_i.emit == EMIT_FCFS) begin
          rem_q <= rem_q - 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // end of batch
      if (cmd_i.clear) begin
        pend_q    <= '0;
        count_q   <= '0;
        sum_q     <= '0;
        dropped_q <= 1'b0;
      end
    end
  end

  // status toward the controller
  assign sts_o.method   = method_q;
  assign sts_o.ptr_done = (ptr_q == count_q);
  assign sts_o.found    = found_q;
  assign sts_o.rem_zero = (rem_q == '0);
  assign sts_o.rem_one  = (rem_q == CntW'(1));
  assign sts_o.out_free = out_free;

  assign out_valid_o          = out_valid_q;
  assign out_served_track_o   = out_trk_q;
  assign out_seek_distance_o  = out_dist_q;
  assign out_at_edge_o        = out_edge_q;
  assign out_total_distance_o = out_tot_q;
  assign out_overflow_o       = out_ovf_q;
  assign out_final_res_o      = out_fin_q;

endmodule

`default_nettype wire

// File: rtl/dss_ctrl.sv
`default_nettype none

module dss_ctrl
  import dss_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_last_i,
  output logic          in_ready_o,
  input  wire dss_sts_t sts_i,
  output dss_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SRCH,
    ST_DRAIN,
    ST_PICK,
    ST_EDGE,
    ST_FRD,
    ST_FEMIT,
    ST_CLEAR
  } state_e;

  state_e state_q, state_d;
  logic   down_q, down_d;
  logic   fin_best;

  // a picked request ends the batch when it is the last pending one,
  // except on the upward sweep where the edge move still follows
  assign fin_best = ((sts_i.method != METHOD_SCAN) || down_q) && sts_i.rem_one;

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d       = state_q;
    down_d        = down_q;
    cmd_o         = '0;
    cmd_o.emit    = EMIT_NONE;
    if (sts_i.method == METHOD_SSTF) begin
      cmd_o.mode = MODE_ANY;
    end else if (down_q) begin
      cmd_o.mode = MODE_DOWN;
    end else begin
      cmd_o.mode = MODE_UP;
    end

    case (state_q)
      ST_IDLE: begin
        cmd_o.store = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start   = 1'b1;
        cmd_o.restart = 1'b1;
        down_d        = 1'b0;
        case (sts_i.method)
          METHOD_FCFS:              state_d = ST_FRD;
          METHOD_SCAN, METHOD_SSTF: state_d = ST_SRCH;
          default:                  state_d = ST_CLEAR;
        endcase
      end
      ST_SRCH: begin
        if (sts_i.ptr_done) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_cmp = 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        if (sts_i.found) begin
          if (sts_i.out_free) begin
            cmd_o.emit    = EMIT_BEST;
            cmd_o.fin     = fin_best;
            cmd_o.restart = 1'b1;
            state_d       = fin_best ? ST_CLEAR : ST_SRCH;
          end
        end else if (sts_i.method == METHOD_SCAN && !down_q) begin
          state_d = ST_EDGE;
        end else begin
          state_d = ST_CLEAR;
        end
      end
      ST_EDGE: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = EMIT_EDGE;
          cmd_o.fin     = sts_i.rem_zero;
          cmd_o.restart = 1'b1;
          down_d        = 1'b1;
          state_d       = sts_i.rem_zero ? ST_CLEAR : ST_SRCH;
        end
      end
      ST_FRD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_FEMIT;
      end
      ST_FEMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_FCFS;
          cmd_o.fin  = sts_i.ptr_done;
          state_d    = sts_i.ptr_done ? ST_CLEAR : ST_FRD;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and sweep direction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      down_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      down_q  <= down_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/disk_seek_scheduler_top.sv
// channel  | dir | word                                        | handshake
// req_i    | in  | track, last                                 | valid / ready
// res_o    | out | served_track, seek_distance, at_edge,       | valid / ready
//          |     | total_distance, overflow, final_res         |
// cfg      | in  | cfg_idx_i, cfg_wdata_i                      | cfg_we_i, no wait
//
// a request word without last is stored, ready stays high
// a last word starts the replay; ready stays low until the last move, if any, is
// loaded into the output register, and rises again after the clear state
// fcfs: each move is one store read followed by one output load
// scan / sstf: each served request follows a linear search through all n
// requests in the batch, one entry read per cycle, then a drain and a pick step
// a stalled result port holds the controller before each move; no clearing
// pass after reset
`default_nettype none

module disk_seek_scheduler_top
  import dss_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DSS_QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dss_req_if.sink                    req_i,
  dss_res_if.source                  res_o
);

  dss_cmd_t cmd;
  dss_sts_t sts;
  logic     in_ready;

  assign req_i.ready = in_ready;

  // sequencer
  dss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_last_i  (req_i.last),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store, search and output register
  dss_datapath #(
    .QueueDepth (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_track_i           (req_i.track),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_ready_i          (res_o.ready),
    .out_valid_o          (res_o.valid),
    .out_served_track_o   (res_o.served_track),
    .out_seek_distance_o  (res_o.seek_distance),
    .out_at_edge_o        (res_o.at_edge),
    .out_total_distance_o (res_o.total_distance),
    .out_overflow_o       (res_o.overflow),
    .out_final_res_o      (res_o.final_res)
  );

endmodule

`default_nettype wire

// File: rtl/dss_checker.sv
`default_nettype none

`include "disk_seek_scheduler_top_assert.svh"

module dss_checker
  import dss_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               req_valid_i,
  input wire logic               req_ready_i,
  input wire logic               req_last_i,
  input wire logic               res_valid_i,
  input wire logic               res_ready_i,
  input wire logic [TRACK_W-1:0] res_served_track_i,
  input wire logic [TRACK_W-1:0] res_seek_distance_i,
  input wire logic [TOT_W-1:0]   res_total_distance_i,
  input wire logic               res_final_res_i
);

  // a stalled result word stays put
  `DSS_ASSERT_NXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_served_track_i) && $stable(res_total_distance_i) && $stable(res_final_res_i), "result word changed under stall")

  // a taken last request closes the input
  `DSS_ASSERT_NXT(a_last_blocks, req_valid_i && req_ready_i && req_last_i, !req_ready_i, "input still open after last request")

  // no result appears while requests are being collected
  `DSS_ASSERT_NXT(a_no_spurious, !res_valid_i && req_ready_i, !res_valid_i, "result word while collecting")

  // the running total includes this move
  `DSS_ASSERT_IMP(a_total_ge_seek, res_valid_i, res_total_distance_i >= TOT_W'(res_seek_distance_i), "total below seek distance")

endmodule

bind disk_seek_scheduler_top dss_checker u_dss_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req_i.valid),
  .req_ready_i          (req_i.ready),
  .req_last_i           (req_i.last),
  .res_valid_i          (res_o.valid),
  .res_ready_i          (res_o.ready),
  .res_served_track_i   (res_o.served_track),
  .res_seek_distance_i  (res_o.seek_distance),
  .res_total_distance_i (res_o.total_distance),
  .res_final_res_i      (res_o.final_res)
);

`default_nettype wire

// File: sim/tb_disk_seek_scheduler_top.sv
`timescale 1ns / 1ps

module tb_disk_seek_scheduler_top;
  import dss_pkg::*;

  // method code with no scheduling behind it
  localparam logic [METHOD_W-1:0] METHOD_NONE = 2'd3;

  localparam int unsigned RAND_ITEMS    = 460;
  localparam int unsigned PHASE_ITEMS   = 36;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned RUN_LIMIT_NS  = 12_000_000;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic               last;
  } req_word_t;

  typedef struct packed {
    logic [TRACK_W-1:0] served_track;
    logic [TRACK_W-1:0] seek_distance;
    logic               at_edge;
    logic [TOT_W-1:0]   total_distance;
    logic               overflow;
    logic               final_res;
  } move_word_t;

  // clock, reset and block inputs, all known from time zero
  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_METHOD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  req_valid = 1'b0;
  logic [TRACK_W-1:0]    req_track = '0;
  logic                  req_last  = 1'b0;
  logic                  res_ready = 1'b0;

  dss_req_if req_bus ();
  dss_res_if res_bus ();

  assign req_bus.valid = req_valid;
  assign req_bus.track = req_track;
  assign req_bus.last  = req_last;
  assign res_bus.ready = res_ready;

  disk_seek_scheduler_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .res_o       (res_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // scheduler mirror: batch store, arm and register copies
  logic [TRACK_W-1:0]  trk_store [DSS_QUEUE_DEPTH];
  bit                  pend_flags [DSS_QUEUE_DEPTH];
  int unsigned         stored_cnt    = 0;
  logic [TRACK_W-1:0]  arm_pos       = '0;
  logic [SUM_W-1:0]    seek_sum      = '0;
  logic                batch_dropped = 1'b0;
  logic [METHOD_W-1:0] sched_method  = METHOD_RESET;
  logic [TRACK_W-1:0]  track_limit   = TRACKS_RESET;

  move_word_t  batch_moves [$];
  move_word_t  move_q [$];
  req_word_t   send_q [$];
  int unsigned mismatch_cnt  = 0;
  int unsigned rand_items    = 0;
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 86;
  logic        hold_flip     = 1'b0;
  logic        hold_seen     = 1'b0;
  int unsigned hold_left     = 0;

  function automatic logic [TRACK_W-1:0] track_gap(logic [TRACK_W-1:0] a,
                                                   logic [TRACK_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // closest pending request on the allowed side, earliest wins a tie
  function automatic int nearest_pending(dss_mode_e mode);
    int                 best;
    logic [TRACK_W-1:0] best_d;
    logic [TRACK_W-1:0] d;
    best   = -1;
    best_d = '0;
    for (int i = 0; i < int'(stored_cnt); i++) begin
      if (!pend_flags[i]) continue;
      if (mode == MODE_UP && trk_store[i] < arm_pos) continue;
      if (mode == MODE_DOWN && trk_store[i] > arm_pos) continue;
      d = track_gap(trk_store[i], arm_pos);
      if (best < 0 || d < best_d) begin
        best   = i;
        best_d = d;
      end
    end
    return best;
  endfunction

  function automatic void arm_move(logic [TRACK_W-1:0] dest, logic to_edge);
    move_word_t         m;
    logic [TRACK_W-1:0] d;
    d                = track_gap(dest, arm_pos);
    seek_sum         = seek_sum + SUM_W'(d);
    arm_pos          = dest;
    m.served_track   = dest;
    m.seek_distance  = d;
    m.at_edge        = to_edge;
    m.total_distance = seek_sum[TOT_W-1:0];
    m.overflow       = batch_dropped;
    m.final_res      = 1'b0;
    batch_moves.push_back(m);
  endfunction

  function automatic void serve_nearest(dss_mode_e mode);
    int idx;
    idx = nearest_pending(mode);
    while (idx >= 0) begin
      pend_flags[idx] = 1'b0;
      arm_move(trk_store[idx], 1'b0);
      idx = nearest_pending(mode);
    end
  endfunction

  // store one request; a last word replays the batch into the move queue
  function automatic void schedule_request(logic [TRACK_W-1:0] t, logic is_last);
    logic [TRACK_W-1:0] trk;
    trk = (t > track_limit) ? track_limit : t;
    if (stored_cnt < DSS_QUEUE_DEPTH) begin
      trk_store[stored_cnt]  = trk;
      pend_flags[stored_cnt] = 1'b1;
      stored_cnt++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (!is_last) return;

    arm_pos = track_limit >> 1;
    batch_moves.delete();
    case (sched_method)
      METHOD_FCFS: begin
        for (int i = 0; i < int'(stored_cnt); i++) begin
          pend_flags[i] = 1'b0;
          arm_move(trk_store[i], 1'b0);
        end
      end
      METHOD_SSTF: serve_nearest(MODE_ANY);
      METHOD_SCAN: begin
        serve_nearest(MODE_UP);
        arm_move(track_limit, 1'b1);
        serve_nearest(MODE_DOWN);
      end
      default: ;
    endcase
    if (batch_moves.size() > 0) batch_moves[batch_moves.size()-1].final_res = 1'b1;
    foreach (batch_moves[k]) move_q.push_back(batch_moves[k]);

    foreach (pend_flags[k]) pend_flags[k] = 1'b0;
    stored_cnt    = 0;
    seek_sum      = '0;
    batch_dropped = 1'b0;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
      mismatch_cnt++;
    end
  endfunction

  // request driver: feeds the next pending word once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    req_word_t w;
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_track <= '0;
      req_last  <= 1'b0;
    end else begin
      if (req_valid && req_bus.ready) schedule_request(req_track, req_last);
      if (!req_valid || req_bus.ready) begin
        if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          w = send_q.pop_front();
          req_valid <= 1'b1;
          req_track <= w.track;
          req_last  <= w.last;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // move monitor and result back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    move_word_t exp_m;
    if (!rst_ni) begin
      res_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (res_bus.valid && res_ready) begin
        if (move_q.size() == 0) begin
          $display("%0t: move expected none got track %0d", $time, res_bus.served_track);
          mismatch_cnt++;
        end else begin
          exp_m = move_q.pop_front();
          check_field("served_track", exp_m.served_track, res_bus.served_track);
          check_field("seek_distance", exp_m.seek_distance, res_bus.seek_distance);
          check_field("at_edge", exp_m.at_edge, res_bus.at_edge);
          check_field("total_distance", exp_m.total_distance, res_bus.total_distance);
          check_field("overflow", exp_m.overflow, res_bus.overflow);
          check_field("final_res", exp_m.final_res, res_bus.final_res);
        end
      end
      if (hold_flip != hold_seen) begin
        hold_seen <= hold_flip;
        hold_left <= HOLD_CYCLES;
        res_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // write both registers back to back while the block is idle
  task automatic set_config(logic [METHOD_W-1:0] m, logic [TRACK_W-1:0] tc);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_METHOD;
    cfg_wdata <= CFG_DATA_W'(m);
    @(posedge clk_i);
    cfg_idx   <= CFG_TRACKS;
    cfg_wdata <= CFG_DATA_W'(tc);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sched_method = m;
    track_limit  = tc;
  endtask

  task automatic queue_item(logic [TRACK_W-1:0] t, logic is_last);
    req_word_t w;
    w.track = t;
    w.last  = is_last;
    send_q.push_back(w);
  endtask

  // hold the sender until every move is back, then let the block go quiet
  task automatic settle();
    while (send_q.size() != 0 || req_valid || move_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_batch(int unsigned n);
    logic [TRACK_W-1:0] t;
    logic [TRACK_W-1:0] center;
    int unsigned        sel;
    center = track_limit >> 1;
    for (int unsigned k = 0; k < n; k++) begin
      sel = $urandom_range(9);
      if (sel < 5) t = TRACK_W'($urandom_range(65535));
      else if (sel < 8) t = TRACK_W'($urandom_range(track_limit));
      else if (sel == 8) t = center + TRACK_W'($urandom_range(3));
      else t = (center > 3) ? center - TRACK_W'($urandom_range(3)) : center;
      queue_item(t, k == n - 1);
    end
    rand_items += n;
  endtask

  function automatic int unsigned batch_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(10, 1);
    if (p < 92) return $urandom_range(32, 11);
    return $urandom_range(40, 33);
  endfunction

  initial begin
    int unsigned         phase_goal;
    int unsigned         phase_no;
    int unsigned         sel;
    logic [TRACK_W-1:0]  tc;
    logic [METHOD_W-1:0] m;
    bit                  hold_done;

    phase_no  = 0;
    hold_done = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // arrival order across the full track range
    set_config(METHOD_FCFS, 16'hFFFF);
    queue_item(16'd0, 1'b0);
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'd12345, 1'b0);
    queue_item(16'd32767, 1'b1);
    settle();

    // elevator with a request at the start track and one at the top edge
    set_config(METHOD_SCAN, 16'hFFFF);
    queue_item(16'd40000, 1'b0);
    queue_item(16'd100, 1'b0);
    queue_item(16'd32767, 1'b0);
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'd32768, 1'b0);
    queue_item(16'd20000, 1'b1);
    settle();

    // shortest seek with equal distances on both sides and a duplicate
    set_config(METHOD_SSTF, 16'hFFFF);
    queue_item(16'd32765, 1'b0);
    queue_item(16'd32769, 1'b0);
    queue_item(16'd32769, 1'b0);
    queue_item(16'd1, 1'b1);
    settle();

    // track limit zero: everything collapses onto track zero
    set_config(METHOD_SCAN, 16'd0);
    queue_item(16'd7, 1'b0);
    queue_item(16'd0, 1'b1);
    settle();

    // single request batch with a track limit of one
    set_config(METHOD_SSTF, 16'd1);
    queue_item(16'd1, 1'b1);
    settle();

    // unused method code discards the batch
    set_config(METHOD_NONE, 16'd1000);
    queue_item(16'd5, 1'b0);
    queue_item(16'd6, 1'b1);
    settle();

    // saturation of an out-of-range track
    set_config(METHOD_FCFS, 16'd100);
    queue_item(16'hFFFF, 1'b1);
    settle();

    // random phases, each with its own method and track count
    while (rand_items < RAND_ITEMS) begin
      if (rand_items < RAND_ITEMS / 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 86;
      end else if (rand_items < 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (phase_no % 3)
        0:       m = METHOD_FCFS;
        1:       m = METHOD_SCAN;
        default: m = METHOD_SSTF;
      endcase
      sel = $urandom_range(9);
      if (sel == 0) tc = 16'hFFFF;
      else if (sel == 1) tc = 16'd1;
      else if (sel == 2) tc = TRACK_W'($urandom_range(255, 2));
      else if (sel == 3) tc = 16'd32768;
      else tc = TRACK_W'($urandom_range(65535, 1));
      set_config(m, tc);
      phase_no++;

      // long result stall while a full batch and the next one queue up
      if (!hold_done && rand_items >= RAND_ITEMS / 3) begin
        hold_done = 1;
        hold_flip = ~hold_flip;
        random_batch(DSS_QUEUE_DEPTH);
        random_batch(12);
      end

      phase_goal = rand_items + PHASE_ITEMS;
      while (rand_items < phase_goal) random_batch(batch_len());
      settle();
    end

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
